[src/sle_pkg.sv]
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, constants and the key map of the scan-code line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

   // Line store geometry
   localparam int LINE_CAP    = 256;
   localparam int LINE_ADDR_W = $clog2(LINE_CAP);
   localparam int LINE_LEN_W  = $clog2(LINE_CAP + 1);

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Result kinds
   localparam logic [1:0] EV_ECHO    = 2'd0;
   localparam logic [1:0] EV_ERASE   = 2'd1;
   localparam logic [1:0] EV_REBOOT  = 2'd2;
   localparam logic [1:0] EV_UNKNOWN = 2'd3;

   // Command codes carried through the queue
   localparam logic [1:0] OP_CHAR  = 2'd0;
   localparam logic [1:0] OP_ERASE = 2'd1;
   localparam logic [1:0] OP_ENTER = 2'd2;

   // Key codes after the decrement (make form)
   localparam logic [6:0] KEY_LSHIFT = 7'h29;
   localparam logic [6:0] KEY_RSHIFT = 7'h35;
   localparam logic [6:0] KEY_CTRL   = 7'h1C;
   localparam logic [6:0] KEY_ALT    = 7'h37;
   localparam logic [6:0] KEY_BKSP   = 7'h0D;
   localparam logic [6:0] KEY_ENTER  = 7'h1B;

   localparam logic [7:0] ERASE_CODE = 8'h08;
   localparam logic [7:0] NO_CHAR    = 8'hFF;

   // Length of the command word and index of the separator after it
   localparam int WORD_LEN = 6;

   // Key map rows: upper byte plain, lower byte shifted
   localparam int KEY_ROWS = 57;
   localparam logic [15:0] KEYMAP [0:KEY_ROWS-1] = '{
      16'h1B1B, 16'h3121, 16'h3240, 16'h3323, 16'h3424, 16'h3525,
      16'h365E, 16'h3726, 16'h382A, 16'h3928, 16'h3029, 16'h2D5F,
      16'h3D2B, 16'h0808, 16'h0909, 16'h7151, 16'h7757, 16'h6545,
      16'h7252, 16'h7454, 16'h7959, 16'h7555, 16'h6949, 16'h6F4F,
      16'h7050, 16'h5B7B, 16'h5D7D, 16'h0A0A, 16'hFFFF, 16'h6141,
      16'h7353, 16'h6444, 16'h6646, 16'h6747, 16'h6848, 16'h6A4A,
      16'h6B4B, 16'h6C4C, 16'h3B3A, 16'h2722, 16'h607E, 16'hFFFF,
      16'h5C7C, 16'h7A5A, 16'h7858, 16'h6343, 16'h7656, 16'h6242,
      16'h6E4E, 16'h6D4D, 16'h2C3C, 16'h2E3E, 16'h2F3F, 16'hFFFF,
      16'hFFFF, 16'hFFFF, 16'h2020
   };

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] code;
   } sle_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } sle_queue_status_type;

   // Map a make code to a character; rows past the map give NO_CHAR
   function automatic logic [7:0] key_lookup(input logic [6:0] key, input logic shift);
      logic [15:0] row;
      row = {NO_CHAR, NO_CHAR};
      if (key < 7'(KEY_ROWS)) begin
         row = KEYMAP[key[5:0]];
      end
      return shift ? row[7:0] : row[15:8];
   endfunction

   // Expected text of the command line: "reboot" followed by a space
   function automatic logic [7:0] reboot_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h72;
         3'd1:    ch = 8'h65;
         3'd2:    ch = 8'h62;
         3'd3:    ch = 8'h6F;
         3'd4:    ch = 8'h6F;
         3'd5:    ch = 8'h74;
         default: ch = 8'h20;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

[src/sle_ram.sv]
// ----------------------------------------------------------------------------
// sle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/sle_front.sv]
// ----------------------------------------------------------------------------
// sle_front
// Accept scan bytes, track the shift keys, and turn make codes into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_front
   import sle_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_keys_enabled,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic [7:0]           req_scan_byte,
   input  wire sle_queue_status_type queue_status,
   output      logic                 push,
   output      sle_cmd_type          push_cmd
);

   logic       keys_en_ff, keys_en_in;
   logic       shift_ff, shift_in;
   logic       accept;
   logic [7:0] key;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !req_stall;
   assign key       = req_scan_byte - 8'd1;

   // Configuration register
   always_comb begin
      keys_en_in = keys_en_ff;
      if (csr_valid) begin
         keys_en_in = csr_keys_enabled;
      end
   end

   // Classify the accepted byte
   always_comb begin
      shift_in      = shift_ff;
      push          = 1'b0;
      push_cmd.op   = OP_CHAR;
      push_cmd.code = key_lookup(key[6:0], shift_ff);
      if (accept && keys_en_ff) begin
         if (key[7]) begin
            if (key[6:0] inside {KEY_LSHIFT, KEY_RSHIFT}) begin
               shift_in = 1'b0;
            end
         end else if (key[6:0] inside {KEY_LSHIFT, KEY_RSHIFT}) begin
            shift_in = 1'b1;
         end else if (key[6:0] inside {KEY_CTRL, KEY_ALT}) begin
            push = 1'b0;
         end else if (key[6:0] == KEY_BKSP) begin
            push        = 1'b1;
            push_cmd.op = OP_ERASE;
         end else if (key[6:0] == KEY_ENTER) begin
            push        = 1'b1;
            push_cmd.op = OP_ENTER;
         end else begin
            push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_en_ff <= 1'b0;
         shift_ff   <= 1'b0;
      end else begin
         keys_en_ff <= keys_en_in;
         shift_ff   <= shift_in;
      end
   end

endmodule

`default_nettype wire

[src/sle_queue.sv]
// ----------------------------------------------------------------------------
// sle_queue
// Short command queue that decouples the front classifier from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_queue
   import sle_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire sle_cmd_type          push_cmd,
   input  wire logic                 pop,
   output      sle_cmd_type          head_cmd,
   output      sle_queue_status_type status
);

   sle_cmd_type              slot_ff [0:QUEUE_DEPTH-1];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_cmd     = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < QUEUE_CNT_W'(QUEUE_DEPTH)))
      else $error("command pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("command popped from an empty queue");
`endif

endmodule

`default_nettype wire

[src/sle_back.sv]
// ----------------------------------------------------------------------------
// sle_back
// Execute queued commands against the line store and register each result.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_back
   import sle_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sle_cmd_type          head_cmd,
   input  wire sle_queue_status_type queue_status,
   output      logic                 pop,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic [1:0]           rsp_event_kind,
   output      logic [7:0]           rsp_char_code
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                   state_ff, state_in;
   logic [LINE_LEN_W-1:0]  len_ff, len_in;
   logic [2:0]             idx_ff, idx_in;
   logic [2:0]             last_ff, last_in;
   logic                   have_ff, have_in;
   logic                   ok_ff, ok_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             kind_ff, kind_in;
   logic [7:0]             code_ff, code_in;

   logic                   slot_free;
   logic [2:0]             cmp_idx;
   logic                   match;
   logic                   wr_en;
   logic                   rd_en;
   logic [LINE_ADDR_W-1:0] rd_addr;
   logic [7:0]             rd_data;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == ST_IDLE) && !queue_status.empty && slot_free;
   assign cmp_idx   = idx_ff - 3'd1;
   assign match     = ok_ff && (rd_data == reboot_char(cmp_idx));
   assign rd_en     = (state_ff == ST_SCAN);
   assign rd_addr   = LINE_ADDR_W'(idx_ff);
   assign wr_en     = pop && (head_cmd.op == OP_CHAR) && (len_ff < LINE_LEN_W'(LINE_CAP));

   // Command execution and enter-key word scan
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      have_in      = have_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      code_in      = code_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               case (head_cmd.op)
                  OP_CHAR: begin
                     rsp_valid_in = 1'b1;
                     kind_in      = EV_ECHO;
                     code_in      = head_cmd.code;
                     if (wr_en) begin
                        len_in = len_ff + 1'b1;
                     end
                  end
                  OP_ERASE: begin
                     if (len_ff != '0) begin
                        len_in       = len_ff - 1'b1;
                        rsp_valid_in = 1'b1;
                        kind_in      = EV_ERASE;
                        code_in      = ERASE_CODE;
                     end
                  end
                  OP_ENTER: begin
                     if (len_ff < LINE_LEN_W'(WORD_LEN)) begin
                        len_in       = '0;
                        rsp_valid_in = 1'b1;
                        kind_in      = EV_UNKNOWN;
                        code_in      = '0;
                     end else begin
                        state_in = ST_SCAN;
                        idx_in   = '0;
                        have_in  = 1'b0;
                        ok_in    = 1'b1;
                        last_in  = (len_ff == LINE_LEN_W'(WORD_LEN)) ?
                                   3'(WORD_LEN - 1) : 3'(WORD_LEN);
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && rsp_stall;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            idx_in  = idx_ff + 3'd1;
            have_in = 1'b1;
            if (have_ff) begin
               ok_in = match;
               if (cmp_idx == last_ff) begin
                  state_in     = ST_IDLE;
                  len_in       = '0;
                  rsp_valid_in = 1'b1;
                  kind_in      = match ? EV_REBOOT : EV_UNKNOWN;
                  code_in      = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      last_ff <= last_in;
      ok_ff   <= ok_in;
      kind_ff <= kind_in;
      code_ff <= code_in;
   end

   sle_ram #(
      .WIDTH (8),
      .DEPTH (LINE_CAP)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff[LINE_ADDR_W-1:0]),
      .wr_data (head_cmd.code),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_char_code  = code_ff;

`ifndef SYNTHESIS
   a_len_in_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LINE_LEN_W'(LINE_CAP))
      else $error("line length beyond capacity");

   a_scan_slot_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !rsp_valid_ff)
      else $error("result pending while the line is scanned");

   a_scan_needs_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (len_ff >= LINE_LEN_W'(WORD_LEN)))
      else $error("line scanned although shorter than the command word");
`endif

endmodule

`default_nettype wire

[src/scancode_line_editor_top.sv]
// A character or erase byte passes through the command queue before its result is
// registered; an enter result follows one line store read per compared character.
// Throughput: one byte per cycle while the 4-entry command queue has room; an enter
// occupies the back end while it scans the line through the single line store read port.
// Reset clears keys_enabled, the shift flag, the line length, the queue and the result
// register at once; the line store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// scancode_line_editor_top
// Set-1 scan-code line editor: front classifier, command queue, back end.
// ----------------------------------------------------------------------------
`default_nettype none

module scancode_line_editor_top
   import sle_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic       csr_keys_enabled,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_scan_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [1:0] rsp_event_kind,
   output      logic [7:0] rsp_char_code
);

   logic                 push;
   sle_cmd_type          push_cmd;
   logic                 pop;
   sle_cmd_type          head_cmd;
   sle_queue_status_type queue_status;

   // Configuration writes always complete in one transfer
   assign csr_ready = 1'b1;

   sle_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_keys_enabled (csr_keys_enabled),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_scan_byte    (req_scan_byte),
      .queue_status     (queue_status),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   sle_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (queue_status)
   );

   sle_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_cmd       (head_cmd),
      .queue_status   (queue_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_kind (rsp_event_kind),
      .rsp_char_code  (rsp_char_code)
   );

endmodule

`default_nettype wire
